// ===== hdl/rqps_pkg.sv =====
// ----------------------------------------------------------------------------
// rqps_pkg
// Shared types and codes for the ready queue with priority select.
// ----------------------------------------------------------------------------
package rqps_pkg;

  localparam int FUNC_W  = 2;
  localparam int PID_W   = 16;
  localparam int PRIO_W  = 8;
  localparam int STAT_W  = 2;
  localparam int CNT_O_W = 5;
  localparam int ENTRY_W = PID_W + PRIO_W;

  // request codes
  localparam logic [FUNC_W-1:0] FN_ENQ   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_DEQ   = 2'd1;
  localparam logic [FUNC_W-1:0] FN_PURGE = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } state_t;

endpackage

// ===== hdl/rqps_ram.sv =====
// ----------------------------------------------------------------------------
// rqps_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module rqps_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/ready_queue_priority_select.sv =====
// ----------------------------------------------------------------------------
// ready_queue_priority_select
// Bounded ready queue of (pid, priority) entries held in one RAM.
// ----------------------------------------------------------------------------
// One request is handled at a time. With n entries held, an enqueue, a
// rejected request or an unknown code goes straight to the result state.
// A dequeue or purge reads the queue through the single RAM read port: a
// scan of n reads (1 read for a FIFO-mode dequeue), then a compaction that
// moves each entry behind the removed one down by one place, one per cycle.
// A finished result sits in the output register while the next request is
// taken. fifo_mode resets to 0 (priority mode); write it only while idle.
// ----------------------------------------------------------------------------
module ready_queue_priority_select
  import rqps_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [PID_W-1:0]  in_pid,
  input  logic [PRIO_W-1:0] in_prio,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [STAT_W-1:0] out_status,
  output logic [PID_W-1:0]  out_pid,
  output logic [PRIO_W-1:0] out_prio,
  output logic [CNT_O_W-1:0] out_count_after,
  output logic              out_is_empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              fifo_mode_r;
  logic [FUNC_W-1:0] func_r, func_nxt;
  logic [PID_W-1:0]  key_r, key_nxt;
  logic [CW-1:0]     len_r, len_nxt;
  logic [CW-1:0]     iss_r, iss_nxt;
  logic              rv_r, rv_nxt;
  logic [CW-1:0]     ridx_r, ridx_nxt;
  logic              found_r, found_nxt;
  logic [CW-1:0]     sel_r, sel_nxt;
  logic [PID_W-1:0]  bpid_r, bpid_nxt;
  logic [PRIO_W-1:0] bprio_r, bprio_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [PID_W-1:0]  out_pid_r, out_pid_nxt;
  logic [PRIO_W-1:0] out_prio_r, out_prio_nxt;
  logic [CW-1:0]     out_cnt_r, out_cnt_nxt;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  logic [PID_W-1:0]  rd_pid;
  logic [PRIO_W-1:0] rd_prio;
  logic              take;
  logic              fin_found;
  logic [CW-1:0]     fin_sel;
  logic [CW-1:0]     fin_sel_p1;
  logic [CW-1:0]     ridx_m1;
  logic [CW-1:0]     count_m1;
  logic [CW+CNT_O_W-1:0] cnt_ext;

  assign rd_pid   = ram_rdata[PRIO_W +: PID_W];
  assign rd_prio  = ram_rdata[PRIO_W-1:0];
  assign ridx_m1  = ridx_r - CW'(1);
  assign count_m1 = count_r - CW'(1);

  // purge: first pid match; dequeue: strict less keeps the earliest minimum
  assign take = (func_r == FN_PURGE) ? (!found_r && (rd_pid == key_r))
                                     : (!found_r || (rd_prio < bprio_r));
  assign fin_found  = found_r || take;
  assign fin_sel    = take ? ridx_r : sel_r;
  assign fin_sel_p1 = fin_sel + CW'(1);

  rqps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      fifo_mode_r <= 1'b0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        fifo_mode_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    key_r        <= key_nxt;
    len_r        <= len_nxt;
    iss_r        <= iss_nxt;
    ridx_r       <= ridx_nxt;
    found_r      <= found_nxt;
    sel_r        <= sel_nxt;
    bpid_r       <= bpid_nxt;
    bprio_r      <= bprio_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_pid_r    <= out_pid_nxt;
    out_prio_r   <= out_prio_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    func_nxt       = func_r;
    key_nxt        = key_r;
    len_nxt        = len_r;
    iss_nxt        = iss_r;
    rv_nxt         = 1'b0;
    ridx_nxt       = ridx_r;
    found_nxt      = found_r;
    sel_nxt        = sel_r;
    bpid_nxt       = bpid_r;
    bprio_nxt      = bprio_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_pid_nxt    = out_pid_r;
    out_prio_nxt   = out_prio_r;
    out_cnt_nxt    = out_cnt_r;
    ram_we         = 1'b0;
    ram_waddr      = count_r[AW-1:0];
    ram_wdata      = {in_pid, in_prio};
    ram_raddr      = iss_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt   = in_func;
          key_nxt    = in_pid;
          found_nxt  = 1'b0;
          sel_nxt    = '0;
          bpid_nxt   = '0;
          bprio_nxt  = '0;
          status_nxt = ST_DONE;
          state_nxt  = S_RESP;
          if (in_func == FN_ENQ) begin
            if (count_r == CW'(DEPTH)) begin
              status_nxt = ST_FULL;
            end else begin
              ram_we    = 1'b1;
              count_nxt = count_r + CW'(1);
            end
          end else if (in_func == FN_DEQ || in_func == FN_PURGE) begin
            if (count_r == '0) begin
              status_nxt = ST_MISS;
            end else begin
              len_nxt   = (in_func == FN_DEQ && fifo_mode_r) ? CW'(1) : count_r;
              ram_raddr = '0;
              rv_nxt    = 1'b1;
              ridx_nxt  = '0;
              iss_nxt   = CW'(1);
              state_nxt = S_SCAN;
            end
          end
        end
      end

      S_SCAN: begin
        if (iss_r < len_r) begin
          rv_nxt   = 1'b1;
          ridx_nxt = iss_r;
          iss_nxt  = iss_r + CW'(1);
        end
        if (rv_r) begin
          if (take) begin
            found_nxt = 1'b1;
            sel_nxt   = ridx_r;
            bpid_nxt  = rd_pid;
            bprio_nxt = rd_prio;
          end
          if (ridx_r == len_r - CW'(1)) begin
            if (!fin_found) begin
              status_nxt = ST_MISS;
              state_nxt  = S_RESP;
            end else if (fin_sel == count_m1) begin
              count_nxt = count_m1;
              state_nxt = S_RESP;
            end else begin
              // compaction: read sel+1 onward, write each one place lower
              ram_raddr = fin_sel_p1[AW-1:0];
              rv_nxt    = 1'b1;
              ridx_nxt  = fin_sel_p1;
              iss_nxt   = fin_sel_p1 + CW'(1);
              state_nxt = S_SHIFT;
            end
          end
        end
      end

      S_SHIFT: begin
        if (iss_r < count_r) begin
          rv_nxt   = 1'b1;
          ridx_nxt = iss_r;
          iss_nxt  = iss_r + CW'(1);
        end
        if (rv_r) begin
          ram_we    = 1'b1;
          ram_waddr = ridx_m1[AW-1:0];
          ram_wdata = ram_rdata;
          if (ridx_r == count_m1) begin
            count_nxt = count_m1;
            state_nxt = S_RESP;
          end
        end
      end

      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_pid_nxt    = bpid_r;
          out_prio_nxt   = bprio_r;
          out_cnt_nxt    = count_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign cnt_ext = {{CNT_O_W{1'b0}}, out_cnt_r};

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_pid         = out_pid_r;
  assign out_prio        = out_prio_r;
  assign out_count_after = cnt_ext[CNT_O_W-1:0];
  assign out_is_empty    = (out_cnt_r == '0);

endmodule

// ===== hdl/rqps_checker.sv =====
// ----------------------------------------------------------------------------
// rqps_checker
// Port-level checks for the ready queue, bound to the top level.
// ----------------------------------------------------------------------------
module rqps_checker
  import rqps_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input logic               clk,
  input logic               rst_n,
  input logic               cfg_we,
  input logic               cfg_wdata,
  input logic               in_valid,
  input logic               in_stall,
  input logic [FUNC_W-1:0]  in_func,
  input logic [PID_W-1:0]   in_pid,
  input logic [PRIO_W-1:0]  in_prio,
  input logic               out_valid,
  input logic               out_stall,
  input logic [STAT_W-1:0]  out_status,
  input logic [PID_W-1:0]   out_pid,
  input logic [PRIO_W-1:0]  out_prio,
  input logic [CNT_O_W-1:0] out_count_after,
  input logic               out_is_empty
);

  localparam logic [CNT_O_W-1:0] FULL_CNT = CNT_O_W'(DEPTH);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_pid)
      && $stable(out_prio) && $stable(out_count_after) && $stable(out_is_empty))
    else $error("result changed while stalled");

  // nothing removed unless the request completed
  a_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL || out_status == ST_MISS)
      |-> out_pid == '0 && out_prio == '0)
    else $error("entry reported on a failed request");

  // a rejected enqueue means the queue is at capacity
  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_count_after == FULL_CNT && !out_is_empty)
    else $error("full status with wrong count");

  // empty flag agrees with the count
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && DEPTH < 32 |-> out_is_empty == (out_count_after == '0))
    else $error("empty flag mismatch");

endmodule

bind ready_queue_priority_select rqps_checker #(.DEPTH(DEPTH)) u_rqps_checker (.*);
